### rtl/ppu_pkg.sv
// Shared types, constants and helpers of the particle pool update block.
`default_nettype none
package ppu_pkg;

	localparam int POOL_SIZE_DEF  = 64;
	localparam int DEPTH_STEP_DEF = 7;
	localparam int LANES          = 6;

	typedef enum logic [2:0] {
		REG_BIRTH_COLOR = 3'd0,
		REG_DEATH_COLOR = 3'd1,
		REG_BIRTH_SIZE  = 3'd2,
		REG_DEATH_SIZE  = 3'd3,
		REG_LIFE_TIME   = 3'd4,
		REG_VEL_SPREAD  = 3'd5,
		REG_SPIN_SPREAD = 3'd6,
		REG_USE_DEPTH   = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EM_MUL,
		S_EM_WR,
		S_RD,
		S_MUL,
		S_UPD,
		S_DIV,
		S_PUSH,
		S_FLUSH
	} ppu_state_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_MUL,
		L_SUM,
		L_DIV,
		L_DONE
	} lerp_state_t;

	// fields rewritten by every tick
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] angle;
		logic [31:0] life_left;
	} dyn_t;

	// fields written only by an emit
	typedef struct packed {
		logic [31:0] z;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] spin;
		logic [31:0] life_total;
		logic [31:0] birth_color;
		logic [31:0] death_color;
		logic [31:0] birth_size;
		logic [31:0] death_size;
	} stat_t;

	typedef struct packed {
		logic rd_en;
		logic dyn_we;
		logic stat_we;
		logic set_alive;
		logic clr_alive;
	} store_req_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] angle;
		logic [15:0] width;
		logic [15:0] height;
		logic [31:0] color;
	} res_t;

	typedef struct packed {
		res_t data;
		logic empty;
		logic last;
	} out_rec_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -64'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/ppu_store.sv
// Particle pool storage: tick-updated and emit-only memories plus live bits.
`default_nettype none
module ppu_store #(
	parameter int POOL_SIZE = ppu_pkg::POOL_SIZE_DEF,
	localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ppu_pkg::store_req_t  req,
	input  wire  [AW-1:0]        rd_addr,
	input  wire  [AW-1:0]        wr_addr,
	input  ppu_pkg::dyn_t        dyn_wdata,
	input  ppu_pkg::stat_t       stat_wdata,
	output ppu_pkg::dyn_t        dyn_rdata,
	output ppu_pkg::stat_t       stat_rdata,
	output logic [POOL_SIZE-1:0] alive
);

	ppu_pkg::dyn_t  dyn_mem  [POOL_SIZE];
	ppu_pkg::stat_t stat_mem [POOL_SIZE];
	ppu_pkg::dyn_t  dyn_rd_q;
	ppu_pkg::stat_t stat_rd_q;
	logic [POOL_SIZE-1:0] alive_q;

	always_ff @(posedge clk) begin
		if (req.dyn_we)
			dyn_mem[wr_addr] <= dyn_wdata;
		if (req.rd_en)
			dyn_rd_q <= dyn_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (req.stat_we)
			stat_mem[wr_addr] <= stat_wdata;
		if (req.rd_en)
			stat_rd_q <= stat_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
		end else begin
			if (req.set_alive)
				alive_q[wr_addr] <= 1'b1;
			if (req.clr_alive)
				alive_q[wr_addr] <= 1'b0;
		end
	end

	assign dyn_rdata  = dyn_rd_q;
	assign stat_rdata = stat_rd_q;
	assign alive      = alive_q;

endmodule
`default_nettype wire

### rtl/ppu_lerp.sv
// Life-ratio interpolation of colour channels and size halves, one quotient bit a cycle.
`default_nettype none
module ppu_lerp (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [31:0] left,
	input  wire  [31:0] total,
	input  wire  [31:0] birth_color,
	input  wire  [31:0] death_color,
	input  wire  [31:0] birth_size,
	input  wire  [31:0] death_size,
	output logic        done,
	output logic [31:0] color,
	output logic [15:0] width,
	output logic [15:0] height
);

	localparam int N = ppu_pkg::LANES;

	ppu_pkg::lerp_state_t state_q, state_d;

	logic [15:0] d_q    [N];
	logic [15:0] b_q    [N];
	logic [47:0] pa_q   [N];
	logic [47:0] pb_q   [N];
	logic [48:0] rem_q  [N];
	logic [15:0] quo_q  [N];
	logic [31:0] tl_q;
	logic [31:0] l_q;
	logic [46:0] div_q;
	logic        tz_q;
	logic [3:0]  cnt_q;
	logic [15:0] d_in   [N];
	logic [15:0] b_in   [N];
	logic [15:0] res    [N];

	// lanes 0..3 colour channels from low byte up, lane 4 width, lane 5 height
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			d_in[i] = {8'd0, death_color[8*i +: 8]};
			b_in[i] = {8'd0, birth_color[8*i +: 8]};
		end
		d_in[4] = death_size[31:16];
		b_in[4] = birth_size[31:16];
		d_in[5] = death_size[15:0];
		b_in[5] = birth_size[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ppu_pkg::L_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			ppu_pkg::L_IDLE: if (start) state_d = ppu_pkg::L_MUL;
			ppu_pkg::L_MUL:  state_d = ppu_pkg::L_SUM;
			ppu_pkg::L_SUM:  state_d = ppu_pkg::L_DIV;
			ppu_pkg::L_DIV:  if (cnt_q == 4'd0) state_d = ppu_pkg::L_DONE;
			ppu_pkg::L_DONE: begin
				done    = 1'b1;
				state_d = ppu_pkg::L_IDLE;
			end
			default:         state_d = ppu_pkg::L_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ppu_pkg::L_SUM) begin
			cnt_q <= 4'd15;
		end else if (state_q == ppu_pkg::L_DIV) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	// numerator is below total << 16, so sixteen restoring steps suffice
	always_ff @(posedge clk) begin
		if (state_q == ppu_pkg::L_IDLE && start) begin
			tl_q  <= total - left;
			l_q   <= left;
			div_q <= {total, 15'd0};
			tz_q  <= (total == 32'd0);
			for (int i = 0; i < N; i++) begin
				d_q[i] <= d_in[i];
				b_q[i] <= b_in[i];
			end
		end
		if (state_q == ppu_pkg::L_MUL) begin
			for (int i = 0; i < N; i++) begin
				pa_q[i] <= d_q[i] * tl_q;
				pb_q[i] <= b_q[i] * l_q;
			end
		end
		if (state_q == ppu_pkg::L_SUM) begin
			for (int i = 0; i < N; i++) begin
				rem_q[i] <= {1'b0, pa_q[i]} + {1'b0, pb_q[i]};
				quo_q[i] <= '0;
			end
		end
		if (state_q == ppu_pkg::L_DIV) begin
			div_q <= div_q >> 1;
			for (int i = 0; i < N; i++) begin
				if (rem_q[i] >= {2'b00, div_q}) begin
					rem_q[i] <= rem_q[i] - {2'b00, div_q};
					quo_q[i] <= {quo_q[i][14:0], 1'b1};
				end else begin
					quo_q[i] <= {quo_q[i][14:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < N; i++)
			res[i] = tz_q ? d_q[i] : quo_q[i];
	end

	assign color  = {res[3][7:0], res[2][7:0], res[1][7:0], res[0][7:0]};
	assign width  = res[4];
	assign height = res[5];

endmodule
`default_nettype wire

### rtl/particle_pool_update_top.sv
// Particle pool update top: request handshakes, config registers, tick/emit sequencer.
// Emit: the request passes S_EM_MUL and S_EM_WR before the next request can be accepted; no result.
// Tick: an empty slot is skipped in S_RD, an expiring slot is cleared in S_MUL, a survivor takes
//   an RMW of the pool memories plus the 16-step interpolation divider; the tick ends in S_FLUSH.
// Results leave through an output register; one finished result is held back to mark last.
// Reset clears the live bits, sequencer, output valid and sets the emit slot to POOL_SIZE-1.
`default_nettype none
module particle_pool_update_top #(
	parameter int POOL_SIZE  = ppu_pkg::POOL_SIZE_DEF,
	parameter int DEPTH_STEP = ppu_pkg::DEPTH_STEP_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [62:0] cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         mode,
	input  wire  [30:0] delta_time,
	input  wire  [31:0] start_x,
	input  wire  [31:0] start_y,
	input  wire  [31:0] start_z,
	input  wire  [31:0] start_angle,
	input  wire  [31:0] base_vel_x,
	input  wire  [31:0] base_vel_y,
	input  wire  [31:0] base_spin,
	input  wire  [15:0] rand_x,
	input  wire  [15:0] rand_y,
	input  wire  [15:0] rand_spin,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [31:0] out_angle,
	output logic [15:0] out_width,
	output logic [15:0] out_height,
	output logic [31:0] out_color,
	output logic        empty_res,
	output logic        last
);

	localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int DW = $clog2(POOL_SIZE * DEPTH_STEP + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SIZE - 1);
	localparam logic [DW-1:0] STEP      = DW'(DEPTH_STEP);

	// configuration
	logic [31:0] birth_color_q, death_color_q, birth_size_q, death_size_q;
	logic [30:0] life_time_q, spin_spread_q;
	logic [62:0] vel_spread_q;
	logic        use_depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_color_q <= 32'hFFFF_FFFF;
			death_color_q <= 32'd0;
			birth_size_q  <= 32'h0100_0100;
			death_size_q  <= 32'd0;
			life_time_q   <= 31'd65536;
			vel_spread_q  <= '0;
			spin_spread_q <= '0;
			use_depth_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (ppu_pkg::cfg_reg_t'(cfg_index))
				ppu_pkg::REG_BIRTH_COLOR: birth_color_q <= cfg_data[31:0];
				ppu_pkg::REG_DEATH_COLOR: death_color_q <= cfg_data[31:0];
				ppu_pkg::REG_BIRTH_SIZE:  birth_size_q  <= cfg_data[31:0];
				ppu_pkg::REG_DEATH_SIZE:  death_size_q  <= cfg_data[31:0];
				ppu_pkg::REG_LIFE_TIME:   life_time_q   <= cfg_data[30:0];
				ppu_pkg::REG_VEL_SPREAD:  vel_spread_q  <= cfg_data;
				ppu_pkg::REG_SPIN_SPREAD: spin_spread_q <= cfg_data[30:0];
				ppu_pkg::REG_USE_DEPTH:   use_depth_q   <= cfg_data[0];
			endcase
		end
	end

	ppu_pkg::ppu_state_t state_q, state_d;
	logic in_acc;
	assign in_ready = (state_q == ppu_pkg::S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// captured request
	logic [30:0] dt_q;
	logic [31:0] sx_q, sy_q, sz_q, sa_q, bvx_q, bvy_q, bsp_q;
	logic [15:0] rx_q, ry_q, rs_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dt_q  <= delta_time;
			sx_q  <= start_x;
			sy_q  <= start_y;
			sz_q  <= start_z;
			sa_q  <= start_angle;
			bvx_q <= base_vel_x;
			bvy_q <= base_vel_y;
			bsp_q <= base_spin;
			rx_q  <= rand_x;
			ry_q  <= rand_y;
			rs_q  <= rand_spin;
		end
	end

	// pool storage
	ppu_pkg::store_req_t  sreq;
	ppu_pkg::dyn_t        dyn_w, dyn_r;
	ppu_pkg::stat_t       stat_w, stat_r;
	logic [POOL_SIZE-1:0] alive;
	logic [AW-1:0]        idx_q, slot_q, wr_addr;

	ppu_store #(.POOL_SIZE(POOL_SIZE)) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (sreq),
		.rd_addr    (idx_q),
		.wr_addr    (wr_addr),
		.dyn_wdata  (dyn_w),
		.stat_wdata (stat_w),
		.dyn_rdata  (dyn_r),
		.stat_rdata (stat_r),
		.alive      (alive)
	);

	assign wr_addr = (state_q == ppu_pkg::S_EM_WR) ? slot_q : idx_q;

	// emit variation: spread * |rand| >> 15, then sign of rand
	logic [15:0] mag_x, mag_y, mag_s;
	logic [47:0] emx_s1, emy_s1, ems_s1;
	assign mag_x = rx_q[15] ? (~rx_q + 16'd1) : rx_q;
	assign mag_y = ry_q[15] ? (~ry_q + 16'd1) : ry_q;
	assign mag_s = rs_q[15] ? (~rs_q + 16'd1) : rs_q;

	always_ff @(posedge clk) begin
		if (state_q == ppu_pkg::S_EM_MUL) begin
			emx_s1 <= {1'b0, vel_spread_q[62:32]} * mag_x;
			emy_s1 <= vel_spread_q[31:0] * mag_y;
			ems_s1 <= {1'b0, spin_spread_q} * mag_s;
		end
	end

	function automatic logic [31:0] vary(input logic [31:0] base, input logic [47:0] p,
		input logic neg);
		logic signed [63:0] b, d;
		b = $signed({{32{base[31]}}, base});
		d = $signed({31'd0, p[47:15]});
		return ppu_pkg::sat32(neg ? b - d : b + d);
	endfunction

	// tick arithmetic
	logic signed [33:0] left_c;
	logic signed [33:0] left_s1;
	logic signed [63:0] pvx, pvy, psp;
	logic signed [63:0] pvx_s1, pvy_s1, psp_s1;
	logic               dies;
	logic signed [63:0] stx, sty, sts;
	logic [31:0]        lerp_l;
	logic [DW-1:0]      depth_q, depth_nx;

	assign left_c = $signed({{2{dyn_r.life_left[31]}}, dyn_r.life_left})
		- $signed({3'd0, dt_q});
	assign dies   = left_c[33] || (left_c == 34'sd0);
	assign pvx    = $signed(stat_r.vel_x) * $signed({1'b0, dt_q});
	assign pvy    = $signed(stat_r.vel_y) * $signed({1'b0, dt_q});
	assign psp    = $signed(stat_r.spin) * $signed({1'b0, dt_q});
	assign stx    = pvx_s1 >>> 16;
	assign sty    = pvy_s1 >>> 16;
	assign sts    = psp_s1 >>> 16;
	assign lerp_l = ({1'b0, left_s1[32:0]} > {2'b00, stat_r.life_total})
		? stat_r.life_total : left_s1[31:0];
	assign depth_nx = use_depth_q ? depth_q + STEP : depth_q;

	always_ff @(posedge clk) begin
		if (state_q == ppu_pkg::S_MUL) begin
			left_s1 <= left_c;
			pvx_s1  <= pvx;
			pvy_s1  <= pvy;
			psp_s1  <= psp;
		end
	end

	// interpolation
	logic        lerp_done;
	logic [31:0] lerp_color;
	logic [15:0] lerp_w, lerp_h;

	ppu_lerp u_lerp (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (state_q == ppu_pkg::S_UPD),
		.left        (lerp_l),
		.total       (stat_r.life_total),
		.birth_color (stat_r.birth_color),
		.death_color (stat_r.death_color),
		.birth_size  (stat_r.birth_size),
		.death_size  (stat_r.death_size),
		.done        (lerp_done),
		.color       (lerp_color),
		.width       (lerp_w),
		.height      (lerp_h)
	);

	// result assembly
	ppu_pkg::res_t cur_q, cur;
	ppu_pkg::res_t pend_q;
	logic          pend_valid_q;
	ppu_pkg::out_rec_t out_q;
	logic          out_valid_q;
	logic          out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cur        = cur_q;
		cur.width  = lerp_w;
		cur.height = lerp_h;
		cur.color  = lerp_color;
	end

	always_ff @(posedge clk) begin
		if (state_q == ppu_pkg::S_UPD) begin
			cur_q.x     <= dyn_w.x;
			cur_q.y     <= dyn_w.y;
			cur_q.angle <= dyn_w.angle;
			cur_q.z     <= ppu_pkg::sat32($signed({{32{stat_r.z[31]}}, stat_r.z})
				+ $signed({{(64-DW){1'b0}}, depth_nx}));
		end
		if (state_q == ppu_pkg::S_DIV && lerp_done)
			cur_q <= cur;
	end

	// next state
	logic slot_end;
	assign slot_end = (idx_q == LAST_SLOT);

	always_comb begin
		state_d = state_q;
		sreq    = '0;
		dyn_w   = dyn_r;
		stat_w  = stat_r;
		unique case (state_q)
			ppu_pkg::S_IDLE:
				if (in_acc)
					state_d = mode ? ppu_pkg::S_RD : ppu_pkg::S_EM_MUL;
			ppu_pkg::S_EM_MUL:
				state_d = ppu_pkg::S_EM_WR;
			ppu_pkg::S_EM_WR: begin
				sreq.dyn_we       = 1'b1;
				sreq.stat_we      = 1'b1;
				sreq.set_alive    = 1'b1;
				dyn_w.x           = sx_q;
				dyn_w.y           = sy_q;
				dyn_w.angle       = sa_q;
				dyn_w.life_left   = {1'b0, life_time_q};
				stat_w.z          = sz_q;
				stat_w.vel_x      = vary(bvx_q, emx_s1, rx_q[15]);
				stat_w.vel_y      = vary(bvy_q, emy_s1, ry_q[15]);
				stat_w.spin       = vary(bsp_q, ems_s1, rs_q[15]);
				stat_w.life_total = {1'b0, life_time_q};
				stat_w.birth_color = birth_color_q;
				stat_w.death_color = death_color_q;
				stat_w.birth_size = birth_size_q;
				stat_w.death_size = death_size_q;
				state_d           = ppu_pkg::S_IDLE;
			end
			ppu_pkg::S_RD:
				if (alive[idx_q]) begin
					sreq.rd_en = 1'b1;
					state_d    = ppu_pkg::S_MUL;
				end else begin
					state_d = slot_end ? ppu_pkg::S_FLUSH : ppu_pkg::S_RD;
				end
			ppu_pkg::S_MUL:
				if (dies) begin
					sreq.dyn_we     = 1'b1;
					sreq.clr_alive  = 1'b1;
					dyn_w.life_left = left_c[31:0];
					state_d = slot_end ? ppu_pkg::S_FLUSH : ppu_pkg::S_RD;
				end else begin
					state_d = ppu_pkg::S_UPD;
				end
			ppu_pkg::S_UPD: begin
				sreq.dyn_we     = 1'b1;
				dyn_w.life_left = left_s1[31:0];
				dyn_w.x = ppu_pkg::sat32($signed({{32{dyn_r.x[31]}}, dyn_r.x}) + stx);
				dyn_w.y = ppu_pkg::sat32($signed({{32{dyn_r.y[31]}}, dyn_r.y}) + sty);
				dyn_w.angle = dyn_r.angle + sts[31:0];
				state_d = ppu_pkg::S_DIV;
			end
			ppu_pkg::S_DIV:
				if (lerp_done) state_d = ppu_pkg::S_PUSH;
			ppu_pkg::S_PUSH:
				if (!pend_valid_q || out_free)
					state_d = slot_end ? ppu_pkg::S_FLUSH : ppu_pkg::S_RD;
			ppu_pkg::S_FLUSH:
				if (out_free) state_d = ppu_pkg::S_IDLE;
			default:
				state_d = ppu_pkg::S_IDLE;
		endcase
	end

	logic slot_adv;
	assign slot_adv = (state_q != state_d) && (state_d == ppu_pkg::S_RD || state_d ==
		ppu_pkg::S_FLUSH) && (state_q != ppu_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppu_pkg::S_IDLE;
			slot_q  <= LAST_SLOT;
			idx_q   <= '0;
			depth_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ppu_pkg::S_EM_WR)
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + AW'(1);
			if (in_acc) begin
				idx_q   <= '0;
				depth_q <= '0;
			end else if (slot_adv || (state_q == ppu_pkg::S_RD && state_d == ppu_pkg::S_RD)) begin
				idx_q <= idx_q + AW'(1);
			end
			if (state_q == ppu_pkg::S_UPD)
				depth_q <= depth_nx;
		end
	end

	// held-back result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ppu_pkg::S_PUSH && (!pend_valid_q || out_free))
				pend_valid_q <= 1'b1;
			else if (state_q == ppu_pkg::S_FLUSH && out_free)
				pend_valid_q <= 1'b0;
			if ((state_q == ppu_pkg::S_PUSH && pend_valid_q && out_free) ||
				(state_q == ppu_pkg::S_FLUSH && out_free))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ppu_pkg::S_PUSH && (!pend_valid_q || out_free))
			pend_q <= cur_q;
		if (state_q == ppu_pkg::S_PUSH && pend_valid_q && out_free) begin
			out_q.data  <= pend_q;
			out_q.empty <= 1'b0;
			out_q.last  <= 1'b0;
		end else if (state_q == ppu_pkg::S_FLUSH && out_free) begin
			out_q.data  <= pend_valid_q ? pend_q : '0;
			out_q.empty <= !pend_valid_q;
			out_q.last  <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = out_q.data.x;
	assign out_y      = out_q.data.y;
	assign out_z      = out_q.data.z;
	assign out_angle  = out_q.data.angle;
	assign out_width  = out_q.data.width;
	assign out_height = out_q.data.height;
	assign out_color  = out_q.data.color;
	assign empty_res  = out_q.empty;
	assign last       = out_q.last;

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !pend_valid_q)
		else $error("held-back result left over after tick");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_res) |-> last)
		else $error("empty result not marked last");
	a_lerp_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		lerp_done |-> (state_q == ppu_pkg::S_DIV))
		else $error("interpolation finished outside divide wait");
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppu_pkg::S_FLUSH && out_free) |=> (out_valid_q && out_q.last))
		else $error("tick ended without a last result");

endmodule
`default_nettype wire

### bench/ppu_checker.sv
// Checker for the particle pool: predicts the result stream from accepted requests and compares.
`timescale 1ns / 100ps
`default_nettype none
module ppu_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [62:0] cfg_data,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire         mode,
	input  wire  [30:0] delta_time,
	input  wire  [31:0] start_x,
	input  wire  [31:0] start_y,
	input  wire  [31:0] start_z,
	input  wire  [31:0] start_angle,
	input  wire  [31:0] base_vel_x,
	input  wire  [31:0] base_vel_y,
	input  wire  [31:0] base_spin,
	input  wire  [15:0] rand_x,
	input  wire  [15:0] rand_y,
	input  wire  [15:0] rand_spin,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire  [31:0] out_x,
	input  wire  [31:0] out_y,
	input  wire  [31:0] out_z,
	input  wire  [31:0] out_angle,
	input  wire  [15:0] out_width,
	input  wire  [15:0] out_height,
	input  wire  [31:0] out_color,
	input  wire         empty_res,
	input  wire         last,
	output int          fail_count,
	output int          pending
);

	localparam int NSLOT = ppu_pkg::POOL_SIZE_DEF;
	localparam int STEP  = ppu_pkg::DEPTH_STEP_DEF;
	localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

	// register copies
	logic [31:0] birth_col, death_col, birth_sz, death_sz;
	logic [30:0] life_cfg, spin_var;
	logic [62:0] vel_var;
	logic        depth_on;

	// pool copy
	logic        live [NSLOT];
	logic [31:0] px [NSLOT], py [NSLOT], pz [NSLOT], ang [NSLOT];
	logic [31:0] vx [NSLOT], vy [NSLOT], spin [NSLOT];
	logic [31:0] life_left [NSLOT], life_total [NSLOT];
	logic [31:0] bcol [NSLOT], dcol [NSLOT], bsz [NSLOT], dsz [NSLOT];
	logic [SW-1:0] slot_ptr;

	ppu_pkg::out_rec_t survivors_q[$];

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] spread_add(input logic [31:0] base,
			input longint unsigned spread, input logic [15:0] r);
		longint b;
		longint rs;
		longint unsigned mag;
		longint d;
		b   = longint'($signed(base));
		rs  = longint'($signed(r));
		mag = (rs < 0) ? -rs : rs;
		d   = longint'((spread * mag) >> 15);
		return clamp32(b + ((rs < 0) ? -d : d));
	endfunction

	function automatic logic [31:0] blend(input logic [31:0] dv, input logic [31:0] bv,
			input longint unsigned l, input longint unsigned total);
		if (total == 0)
			return dv;
		return 32'((longint'(dv) * (total - l) + longint'(bv) * l) / total);
	endfunction

	task automatic emit_particle();
		logic [SW-1:0] s;
		s = slot_ptr;
		live[s]       = 1'b1;
		px[s]         = start_x;
		py[s]         = start_y;
		pz[s]         = start_z;
		ang[s]        = start_angle;
		vx[s]         = spread_add(base_vel_x, vel_var[62:32], rand_x);
		vy[s]         = spread_add(base_vel_y, vel_var[31:0], rand_y);
		spin[s]       = spread_add(base_spin, spin_var, rand_spin);
		life_left[s]  = {1'b0, life_cfg};
		life_total[s] = {1'b0, life_cfg};
		bcol[s]       = birth_col;
		dcol[s]       = death_col;
		bsz[s]        = birth_sz;
		dsz[s]        = death_sz;
		slot_ptr      = (s == SW'(NSLOT - 1)) ? '0 : s + SW'(1);
	endtask

	task automatic advance_pool();
		longint dt;
		longint left;
		longint move;
		longint depth;
		longint unsigned l;
		longint unsigned total;
		logic [31:0] col;
		ppu_pkg::out_rec_t r;
		int n;
		dt    = longint'(delta_time);
		depth = 0;
		n     = 0;
		for (int i = 0; i < NSLOT; i++) begin
			if (!live[i])
				continue;
			left = longint'($signed(life_left[i])) - dt;
			life_left[i] = left[31:0];
			if (left <= 0) begin
				live[i] = 1'b0;
				continue;
			end
			move  = longint'($signed(vx[i])) * dt;
			px[i] = clamp32(longint'($signed(px[i])) + (move >>> 16));
			move  = longint'($signed(vy[i])) * dt;
			py[i] = clamp32(longint'($signed(py[i])) + (move >>> 16));
			move  = longint'($signed(spin[i])) * dt;
			move  = move >>> 16;
			ang[i] = ang[i] + move[31:0];
			if (depth_on)
				depth += STEP;
			total = life_total[i];
			l     = longint'(left);
			if (l > total)
				l = total;
			for (int c = 0; c < 4; c++)
				col[c*8 +: 8] = 8'(blend(32'(dcol[i][c*8 +: 8]), 32'(bcol[i][c*8 +: 8]),
					l, total));
			r             = '0;
			r.data.x      = px[i];
			r.data.y      = py[i];
			r.data.z      = clamp32(longint'($signed(pz[i])) + depth);
			r.data.angle  = ang[i];
			r.data.width  = 16'(blend(32'(dsz[i][31:16]), 32'(bsz[i][31:16]), l, total));
			r.data.height = 16'(blend(32'(dsz[i][15:0]), 32'(bsz[i][15:0]), l, total));
			r.data.color  = col;
			survivors_q.push_back(r);
			n++;
		end
		if (n == 0) begin
			r       = '0;
			r.empty = 1'b1;
			r.last  = 1'b1;
			survivors_q.push_back(r);
		end else begin
			survivors_q[survivors_q.size()-1].last = 1'b1;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ppu_pkg::out_rec_t e;
		if (!arst_n) begin
			birth_col = 32'hFFFF_FFFF;
			death_col = '0;
			birth_sz  = 32'd16777472;
			death_sz  = '0;
			life_cfg  = 31'd65536;
			vel_var   = '0;
			spin_var  = '0;
			depth_on  = 1'b0;
			for (int i = 0; i < NSLOT; i++)
				live[i] = 1'b0;
			slot_ptr = SW'(NSLOT - 1);
			survivors_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (survivors_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual x=%h last=%b",
						$time, out_x, last);
					fail_count++;
				end else begin
					e = survivors_q.pop_front();
					check_field("out_x", e.data.x, out_x);
					check_field("out_y", e.data.y, out_y);
					check_field("out_z", e.data.z, out_z);
					check_field("out_angle", e.data.angle, out_angle);
					check_field("out_width", 32'(e.data.width), 32'(out_width));
					check_field("out_height", 32'(e.data.height), 32'(out_height));
					check_field("out_color", e.data.color, out_color);
					check_field("empty_res", 32'(e.empty), 32'(empty_res));
					check_field("last", 32'(e.last), 32'(last));
				end
			end
			if (cfg_we) begin
				unique case (ppu_pkg::cfg_reg_t'(cfg_index))
					ppu_pkg::REG_BIRTH_COLOR: birth_col = cfg_data[31:0];
					ppu_pkg::REG_DEATH_COLOR: death_col = cfg_data[31:0];
					ppu_pkg::REG_BIRTH_SIZE:  birth_sz  = cfg_data[31:0];
					ppu_pkg::REG_DEATH_SIZE:  death_sz  = cfg_data[31:0];
					ppu_pkg::REG_LIFE_TIME:   life_cfg  = cfg_data[30:0];
					ppu_pkg::REG_VEL_SPREAD:  vel_var   = cfg_data;
					ppu_pkg::REG_SPIN_SPREAD: spin_var  = cfg_data[30:0];
					ppu_pkg::REG_USE_DEPTH:   depth_on  = cfg_data[0];
				endcase
			end
			if (in_valid && in_ready) begin
				if (mode)
					advance_pool();
				else
					emit_particle();
			end
			pending = survivors_q.size();
		end
	end
endmodule
`default_nettype wire

### bench/tb_particle_pool_update_top.sv
// Testbench top for the particle pool: clock, reset, request stimulus, config phases, verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_particle_pool_update_top;

	localparam longint CYCLE_LIMIT = 10000000;

	typedef struct {
		logic        mode;
		logic [30:0] dt;
		logic [31:0] x, y, z, a, bvx, bvy, bspin;
		logic [15:0] rx, ry, rs;
	} request_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [62:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [30:0] delta_time;
	logic [31:0] start_x, start_y, start_z, start_angle;
	logic [31:0] base_vel_x, base_vel_y, base_spin;
	logic [15:0] rand_x, rand_y, rand_spin;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] out_x, out_y, out_z, out_angle, out_color;
	logic [15:0] out_width, out_height;
	logic        empty_res;
	logic        last;
	int          fail_count;
	int          pending;
	logic        calm;
	longint      cycles;

	particle_pool_update_top u_top (.*);

	ppu_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send(input request_t q);
		logic ok;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= q.mode;
		delta_time  <= q.dt;
		start_x     <= q.x;
		start_y     <= q.y;
		start_z     <= q.z;
		start_angle <= q.a;
		base_vel_x  <= q.bvx;
		base_vel_y  <= q.bvy;
		base_spin   <= q.bspin;
		rand_x      <= q.rx;
		rand_y      <= q.ry;
		rand_spin   <= q.rs;
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
	endtask

	function automatic request_t tick_req(input logic [30:0] dt);
		request_t q;
		q      = '{default: '0};
		q.mode = 1'b1;
		q.dt   = dt;
		q.x    = $urandom;
		q.rx   = $urandom;
		return q;
	endfunction

	function automatic request_t emit_req(input logic [31:0] x, y, z, a, bvx, bvy, bspin,
			input logic [15:0] rx, ry, rs);
		request_t q;
		q = '{1'b0, 31'($urandom), x, y, z, a, bvx, bvy, bspin, rx, ry, rs};
		return q;
	endfunction

	function automatic logic [15:0] rand_q15();
		return 16'($signed($urandom_range(0, 65534)) - 32767);
	endfunction

	function automatic request_t random_req();
		logic [30:0] dt;
		if ($urandom_range(0, 99) < 60)
			return emit_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, rand_q15(), rand_q15(), rand_q15());
		dt = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 16'h4000));
		return tick_req(dt);
	endfunction

	// wait out every expected result, then the tail of any emit in flight
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_regs(input logic [31:0] bc, dc, bs, ds, input logic [30:0] lt,
			input logic [62:0] vs, input logic [30:0] ss, input logic ud);
		logic [62:0] vals [8];
		vals = '{63'(bc), 63'(dc), 63'(bs), 63'(ds), 63'(lt), vs, 63'(ss), 63'(ud)};
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [31:0] pmax, pmin;
		logic [15:0] rmax, rmin;
		pmax = 32'h7FFF_FFFF;
		pmin = 32'h8000_0000;
		rmax = 16'sd32767;
		rmin = -16'sd32767;
		cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		{mode, delta_time, start_x, start_y, start_z, start_angle} = '0;
		{base_vel_x, base_vel_y, base_spin, rand_x, rand_y, rand_spin} = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty pool, one particle aging out
		send(tick_req(31'h0));
		send(emit_req(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0002_0000,
			32'hFFFE_0000, 32'h0003_0000, 16'h0, 16'h0, 16'h0));
		send(tick_req(31'h4000));
		send(tick_req(31'h0));
		send(tick_req(31'h1_0000));
		settle();

		// extremes: saturating motion, full spreads, depth on
		write_regs(32'h1234_5678, 32'hFEDC_BA98, 32'hFFFF_0001, 32'h0100_FFFF,
			31'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
		send(emit_req(pmax, pmin, pmax, pmax, pmax, pmin, pmax, rmax, rmin, rmax));
		send(emit_req(pmin, pmax, pmin, pmin, pmin, pmax, pmin, rmin, rmax, rmin));
		send(emit_req(32'h0, 32'h0, pmax - 3, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
			16'h0, 16'h0, 16'h0));
		send(emit_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h1,
			32'h8000_0001, 16'h0001, 16'hFFFF, 16'h7FFF));
		send(tick_req(31'h1_0000));
		send(tick_req(31'h0));
		send(tick_req(31'h7FFF_0000));
		send(tick_req(31'h7FFF_FFFF));
		send(tick_req(31'h7FFF_FFFF));
		settle();

		// zero lifetime dies on the next tick even with no elapsed time
		write_regs(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 31'h0, 63'h0, 31'h0, 1'b0);
		send(emit_req(32'h10, 32'h20, 32'h30, 32'h40, 32'h0, 32'h0, 32'h0,
			16'h0, 16'h0, 16'h0));
		send(tick_req(31'h0));
		settle();

		for (int p = 0; p < 5; p++) begin
			case (p)
				1: write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					31'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
				3: write_regs(32'h0, 32'h0, 32'h0, 32'h0, 31'h1, 63'h0, 31'h0, 1'b0);
				default: write_regs($urandom, $urandom, $urandom, $urandom,
					31'($urandom_range(16'h100, 20'h60000)),
					{31'($urandom_range(0, 20'h80000)), 32'($urandom_range(0, 20'h80000))},
					31'($urandom), 1'($urandom));
			endcase
			calm = (p == 4);
			for (int k = 0; k < 70; k++)
				send(random_req());
			send(tick_req(31'($urandom_range(0, 16'h4000))));
			settle();
		end

		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
rtl/ppu_pkg.sv
rtl/ppu_store.sv
rtl/ppu_lerp.sv
rtl/particle_pool_update_top.sv
bench/ppu_checker.sv
bench/tb_particle_pool_update_top.sv
